// ===== hdl/npq_pkg.sv =====
// ----------------------------------------------------------------------------
// npq_pkg: shared types and constants for the nearest palette color quantizer
// Holds the channel widths, request and register codes, and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package npq_pkg;

    localparam int CHAN_W     = 8;
    localparam int IDX_W      = 7;
    localparam int SLOT_W     = 6;
    localparam int COLOR_W    = 3 * CHAN_W;
    localparam int SQ_W       = 2 * CHAN_W;
    localparam int DIST_W     = SQ_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CHAN_W-1:0] WHITE_LEVEL = 8'hFF;

    // Request codes carried by req_type
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_RED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_GREEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_BLUE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic             load_entry;   // write the input color into the palette
        logic             accept_pixel; // latch pixel, clear best, preset fixed answer
        logic             issue;        // read palette entry rd_idx as a candidate
        logic             issue_white;  // inject the implicit white candidate
        logic [IDX_W-1:0] rd_idx;
        logic             out_load;     // move the best candidate into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done; // last candidate compared, best is final
        logic out_free;  // output register can take a result this cycle
    } sts_t;

endpackage

// ===== hdl/npq_ram.sv =====
// ----------------------------------------------------------------------------
// npq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined until written.
// ----------------------------------------------------------------------------
module npq_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/npq_ctrl.sv =====
// ----------------------------------------------------------------------------
// npq_ctrl: transaction sequencer
// Accepts load and pixel transactions, walks the palette one entry a cycle,
// injects the implicit white candidate and hands the result to the output.
// ----------------------------------------------------------------------------
module npq_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      req_type,
    input  logic                      fixed_mode,
    input  logic [npq_pkg::IDX_W-1:0] eff_count,
    input  npq_pkg::sts_t             sts,
    output npq_pkg::cmd_t             cmd,
    output logic                      in_stall
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WAIT_OUT
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [npq_pkg::IDX_W-1:0] idx_reg;
    logic [npq_pkg::IDX_W-1:0] idx_next;
    logic                      accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_idx = idx_reg;
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == npq_pkg::REQ_LOAD)
                    begin
                        cmd.load_entry = 1'b1;
                    end
                    else
                    begin
                        cmd.accept_pixel = 1'b1;
                        idx_next         = '0;
                        state_next       = fixed_mode ? ST_WAIT_OUT : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (idx_reg < eff_count)
                begin
                    cmd.issue = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    cmd.issue_white = 1'b1;
                    state_next      = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait for the white candidate to leave the compare stage
                if (sts.scan_done)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WAIT_OUT;
                    end
                end
            end
            ST_WAIT_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== hdl/npq_datapath.sv =====
// ----------------------------------------------------------------------------
// npq_datapath: distance pipeline, best-candidate tracking and output register
// Candidates flow through a read stage, a squaring stage and a compare stage.
// ----------------------------------------------------------------------------
module npq_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  npq_pkg::cmd_t                cmd,
    output npq_pkg::sts_t                sts,
    input  logic [npq_pkg::CHAN_W-1:0]   in_red,
    input  logic [npq_pkg::CHAN_W-1:0]   in_green,
    input  logic [npq_pkg::CHAN_W-1:0]   in_blue,
    input  logic [npq_pkg::CHAN_W-1:0]   in_alpha,
    input  logic                         fixed_mode,
    input  logic [npq_pkg::CHAN_W-1:0]   fixed_red,
    input  logic [npq_pkg::CHAN_W-1:0]   fixed_green,
    input  logic [npq_pkg::CHAN_W-1:0]   fixed_blue,
    input  logic [npq_pkg::IDX_W-1:0]    eff_count,
    input  logic [npq_pkg::COLOR_W-1:0]  ram_rdata,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic [npq_pkg::CHAN_W-1:0]   out_red,
    output logic [npq_pkg::CHAN_W-1:0]   out_green,
    output logic [npq_pkg::CHAN_W-1:0]   out_blue,
    output logic [npq_pkg::IDX_W-1:0]    chosen_index
);

    localparam int CW = npq_pkg::CHAN_W;
    localparam logic [npq_pkg::COLOR_W-1:0] WHITE_COLOR =
        {npq_pkg::WHITE_LEVEL, npq_pkg::WHITE_LEVEL, npq_pkg::WHITE_LEVEL};

    function automatic logic [npq_pkg::SQ_W-1:0] sq_diff(
        input logic [CW-1:0] a,
        input logic [CW-1:0] b
    );
        logic [CW-1:0] d;
        begin
            d       = (a > b) ? (a - b) : (b - a);
            sq_diff = d * d;
        end
    endfunction

    // pixel under search
    logic [CW-1:0] pix_red_reg;
    logic [CW-1:0] pix_green_reg;
    logic [CW-1:0] pix_blue_reg;

    // read stage
    logic                          s1_valid_reg;
    logic                          s1_white_reg;
    logic [npq_pkg::IDX_W-1:0]     s1_idx_reg;
    logic [npq_pkg::COLOR_W-1:0]   s1_color;

    // squaring stage
    logic                          s2_valid_reg;
    logic                          s2_white_reg;
    logic [npq_pkg::IDX_W-1:0]     s2_idx_reg;
    logic [npq_pkg::COLOR_W-1:0]   s2_color_reg;
    logic [npq_pkg::SQ_W-1:0]      s2_sq_red_reg;
    logic [npq_pkg::SQ_W-1:0]      s2_sq_green_reg;
    logic [npq_pkg::SQ_W-1:0]      s2_sq_blue_reg;

    // compare stage and best candidate
    logic [npq_pkg::DIST_W-1:0]    cand_dist;
    logic                          take;
    logic                          have_reg;
    logic                          done_reg;
    logic [npq_pkg::DIST_W-1:0]    best_dist_reg;
    logic [npq_pkg::COLOR_W-1:0]   best_color_reg;
    logic [npq_pkg::IDX_W-1:0]     best_idx_reg;

    // output register
    logic                          out_valid_reg;
    logic [npq_pkg::COLOR_W-1:0]   out_color_reg;
    logic [npq_pkg::IDX_W-1:0]     out_idx_reg;

    assign s1_color = s1_white_reg ? WHITE_COLOR : ram_rdata;

    assign cand_dist = npq_pkg::DIST_W'(s2_sq_red_reg) + npq_pkg::DIST_W'(s2_sq_green_reg)
                     + npq_pkg::DIST_W'(s2_sq_blue_reg);
    // strict less keeps the earliest candidate on a tie
    assign take = s2_valid_reg && (!have_reg || (cand_dist < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            have_reg      <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue || cmd.issue_white;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg && s2_white_reg;
            if (cmd.accept_pixel)
            begin
                have_reg <= 1'b0;
            end
            else if (take)
            begin
                have_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_pixel)
        begin
            pix_red_reg   <= in_red;
            pix_green_reg <= in_green;
            pix_blue_reg  <= in_blue;
        end

        s1_white_reg <= cmd.issue_white;
        s1_idx_reg   <= cmd.issue_white ? eff_count : cmd.rd_idx;

        s2_white_reg    <= s1_white_reg;
        s2_idx_reg      <= s1_idx_reg;
        s2_color_reg    <= s1_color;
        s2_sq_red_reg   <= sq_diff(pix_red_reg,   s1_color[3*CW-1:2*CW]);
        s2_sq_green_reg <= sq_diff(pix_green_reg, s1_color[2*CW-1:CW]);
        s2_sq_blue_reg  <= sq_diff(pix_blue_reg,  s1_color[CW-1:0]);

        if (cmd.accept_pixel)
        begin
            // fixed mode answers at once: fixed color when opaque, else white
            if (fixed_mode)
            begin
                best_idx_reg   <= eff_count;
                best_color_reg <= (in_alpha != '0) ? {fixed_red, fixed_green, fixed_blue}
                                                   : WHITE_COLOR;
            end
        end
        else if (take)
        begin
            best_dist_reg  <= cand_dist;
            best_color_reg <= s2_color_reg;
            best_idx_reg   <= s2_idx_reg;
        end

        if (cmd.out_load)
        begin
            out_color_reg <= best_color_reg;
            out_idx_reg   <= best_idx_reg;
        end
    end

    assign sts.scan_done = done_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign out_red      = out_color_reg[3*CW-1:2*CW];
    assign out_green    = out_color_reg[2*CW-1:CW];
    assign out_blue     = out_color_reg[CW-1:0];
    assign chosen_index = out_idx_reg;

endmodule

// ===== hdl/nearest_palette_color_quantizer.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_quantizer: maps pixels to the nearest palette color
// Load transactions fill a palette RAM; pixel transactions search it plus an
// implicit white entry, or take a fixed color in fixed mode.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ---------------------------------------
//  input    in         in_valid / in_stall  req_type, entry_index, in_red..in_alpha
//  output   out        out_valid/out_stall  out_red, out_green, out_blue, chosen_index
//  config   in         cfg_write_en         cfg_index, cfg_data
//
//  A load transaction does not stall the input. A nearest-mode pixel scans N
//  entries, N being palette_count saturated to PALETTE_DEPTH: the single palette
//  RAM read port delivers one entry per cycle, then white and three pipeline
//  stages follow. A fixed-mode pixel skips the scan. Reset clears the configuration
//  and control state; the palette is undefined until loaded and needs no clearing
//  pass. A stalled result waits in the output register while loads keep flowing;
//  a following pixel holds at the end of its search until the register frees up.
//
module nearest_palette_color_quantizer #(
    parameter int PALETTE_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             req_type,
    input  logic [npq_pkg::SLOT_W-1:0]       entry_index,
    input  logic [npq_pkg::CHAN_W-1:0]       in_red,
    input  logic [npq_pkg::CHAN_W-1:0]       in_green,
    input  logic [npq_pkg::CHAN_W-1:0]       in_blue,
    input  logic [npq_pkg::CHAN_W-1:0]       in_alpha,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [npq_pkg::CHAN_W-1:0]       out_red,
    output logic [npq_pkg::CHAN_W-1:0]       out_green,
    output logic [npq_pkg::CHAN_W-1:0]       out_blue,
    output logic [npq_pkg::IDX_W-1:0]        chosen_index,

    input  logic                             cfg_write_en,
    input  logic [npq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [npq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    // wide enough for the slot, the count and depths up to 511
    localparam int CMP_W  = 9;
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(PALETTE_DEPTH);

    // configuration registers
    logic                        fixed_mode_reg;
    logic [npq_pkg::CHAN_W-1:0]  fixed_red_reg;
    logic [npq_pkg::CHAN_W-1:0]  fixed_green_reg;
    logic [npq_pkg::CHAN_W-1:0]  fixed_blue_reg;
    logic [npq_pkg::IDX_W-1:0]   palette_count_reg;

    logic [npq_pkg::IDX_W-1:0]   eff_count;
    logic [CMP_W-1:0]            count_ext;
    logic [CMP_W-1:0]            slot_ext;
    logic [CMP_W-1:0]            rd_idx_ext;
    logic                        slot_ok;
    logic                        ram_wr_en;
    logic [npq_pkg::COLOR_W-1:0] ram_rdata;

    npq_pkg::cmd_t               cmd;
    npq_pkg::sts_t               sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_mode_reg    <= 1'b0;
            fixed_red_reg     <= '0;
            fixed_green_reg   <= '0;
            fixed_blue_reg    <= '0;
            palette_count_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                npq_pkg::REG_FIXED_MODE:    fixed_mode_reg    <= cfg_data[0];
                npq_pkg::REG_FIXED_RED:     fixed_red_reg     <= cfg_data;
                npq_pkg::REG_FIXED_GREEN:   fixed_green_reg   <= cfg_data;
                npq_pkg::REG_FIXED_BLUE:    fixed_blue_reg    <= cfg_data;
                npq_pkg::REG_PALETTE_COUNT: palette_count_reg <= cfg_data[npq_pkg::IDX_W-1:0];
                default:                    ;
            endcase
        end
    end

    // saturate the count to the palette depth; it only takes effect for depths below 127
    assign count_ext = CMP_W'(palette_count_reg);
    assign eff_count = (count_ext > DEPTH_CMP) ? DEPTH_CMP[npq_pkg::IDX_W-1:0]
                                               : palette_count_reg;

    // drop loads aimed past the end of the palette
    assign slot_ext  = CMP_W'(entry_index);
    assign slot_ok   = (slot_ext < DEPTH_CMP);
    assign ram_wr_en = cmd.load_entry && slot_ok;

    assign rd_idx_ext = CMP_W'(cmd.rd_idx);

    npq_ram #(
        .WIDTH (npq_pkg::COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_ext[ADDR_W-1:0]),
        .wr_data ({in_red, in_green, in_blue}),
        .rd_en   (cmd.issue),
        .rd_addr (rd_idx_ext[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    npq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .req_type   (req_type),
        .fixed_mode (fixed_mode_reg),
        .eff_count  (eff_count),
        .sts        (sts),
        .cmd        (cmd),
        .in_stall   (in_stall)
    );

    npq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .in_alpha     (in_alpha),
        .fixed_mode   (fixed_mode_reg),
        .fixed_red    (fixed_red_reg),
        .fixed_green  (fixed_green_reg),
        .fixed_blue   (fixed_blue_reg),
        .eff_count    (eff_count),
        .ram_rdata    (ram_rdata),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .chosen_index (chosen_index)
    );

    // a pixel transaction always occupies the sequencer after it is accepted
    a_pixel_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (req_type == npq_pkg::REQ_PIXEL)) |=> in_stall)
        else $error("input not stalled after pixel transaction");

    // a load completes without stalling and leaves the input open
    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (req_type == npq_pkg::REQ_LOAD)) |=> !in_stall)
        else $error("input stalled after load transaction");

    // a result only appears while a pixel transaction is in flight
    a_result_from_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result produced without a pixel in flight");

endmodule

// ===== dv/tb_nearest_palette_color_quantizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_quantizer: self-checking bench for the quantizer
// Drives load and pixel transactions with random idling on both channels,
// predicts each pixel's chosen color and slot from a local copy of the palette
// and registers, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_quantizer;
    import npq_pkg::*;

    localparam int DEPTH        = 64;
    // Longest pixel search covers all DEPTH entries plus white; give the block a margin on top.
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 90;

    // One input transaction: a palette load or a pixel.
    typedef struct packed {
        logic              req;
        logic [SLOT_W-1:0] slot;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } quant_req_t;

    // One result transaction: the chosen color and its palette slot.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [IDX_W-1:0]  slot_idx;
    } quant_color_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  req_type;
    logic [SLOT_W-1:0]     entry_index;
    logic [CHAN_W-1:0]     in_red;
    logic [CHAN_W-1:0]     in_green;
    logic [CHAN_W-1:0]     in_blue;
    logic [CHAN_W-1:0]     in_alpha;
    logic                  out_valid;
    logic                  out_stall;
    logic [CHAN_W-1:0]     out_red;
    logic [CHAN_W-1:0]     out_green;
    logic [CHAN_W-1:0]     out_blue;
    logic [IDX_W-1:0]      chosen_index;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Local copy of the block's state, advanced on every accepted transaction
    logic [COLOR_W-1:0] palette_model [DEPTH];
    logic               fixed_mode_q;
    logic [CHAN_W-1:0]  fixed_red_q;
    logic [CHAN_W-1:0]  fixed_green_q;
    logic [CHAN_W-1:0]  fixed_blue_q;
    logic [IDX_W-1:0]   count_q;

    // Colors still owed by the block, oldest first
    quant_color_t color_queue [$];

    int err_count   = 0;
    int cycle_count = 0;
    // Cycles of forced output hold-off; loaded by a test, counted down by the sink
    int hold_left   = 0;
    // Clear to run both channels without random idling
    bit idle_on     = 1'b1;

    nearest_palette_color_quantizer #(
        .PALETTE_DEPTH (DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .in_alpha     (in_alpha),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .chosen_index (chosen_index),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, color_queue.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Exact squared RGB distance between a pixel and a packed palette color
    function automatic int sq_dist(quant_req_t px, logic [COLOR_W-1:0] c);
        int dr;
        int dg;
        int db;
        dr = int'(px.red)   - int'(c[23:16]);
        dg = int'(px.green) - int'(c[15:8]);
        db = int'(px.blue)  - int'(c[7:0]);
        return dr * dr + dg * dg + db * db;
    endfunction

    function automatic quant_color_t nearest_color(quant_req_t px);
        quant_color_t best;
        int           span;
        int           best_dist;
        int           cand_dist;
        // Counts above the store depth saturate; the saturated value is also the
        // slot reported for white and for every fixed-mode answer.
        span          = (int'(count_q) > DEPTH) ? DEPTH : int'(count_q);
        best.red      = WHITE_LEVEL;
        best.green    = WHITE_LEVEL;
        best.blue     = WHITE_LEVEL;
        best.slot_idx = IDX_W'(span);
        if (fixed_mode_q)
        begin
            // Opaque pixels take the fixed color, transparent ones stay white
            if (px.alpha != '0)
            begin
                best.red   = fixed_red_q;
                best.green = fixed_green_q;
                best.blue  = fixed_blue_q;
            end
        end
        else
        begin
            best_dist = -1;
            // Strict compare: on a tie the earliest slot keeps the win
            for (int i = 0; i < span; i++)
            begin
                cand_dist = sq_dist(px, palette_model[i]);
                if (best_dist < 0 || cand_dist < best_dist)
                begin
                    best_dist     = cand_dist;
                    best.slot_idx = IDX_W'(i);
                    best.red      = palette_model[i][23:16];
                    best.green    = palette_model[i][15:8];
                    best.blue     = palette_model[i][7:0];
                end
            end
            // Implicit white comes last, so a loaded white entry beats it on a tie
            cand_dist = sq_dist(px, {WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL});
            if (best_dist < 0 || cand_dist < best_dist)
            begin
                best.slot_idx = IDX_W'(span);
                best.red      = WHITE_LEVEL;
                best.green    = WHITE_LEVEL;
                best.blue     = WHITE_LEVEL;
            end
        end
        return best;
    endfunction

    // ------------------------------------------------------------------------
    // Transaction builders
    // ------------------------------------------------------------------------

    function automatic quant_req_t load_item(int slot, logic [CHAN_W-1:0] r,
                                             logic [CHAN_W-1:0] g,
                                             logic [CHAN_W-1:0] b);
        quant_req_t it;
        it.req   = REQ_LOAD;
        it.slot  = SLOT_W'(slot);
        it.red   = r;
        it.green = g;
        it.blue  = b;
        // Loads ignore alpha; keep it moving anyway
        it.alpha = CHAN_W'($urandom);
        return it;
    endfunction

    function automatic quant_req_t pixel_item(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                              logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a);
        quant_req_t it;
        it.req   = REQ_PIXEL;
        // Pixels ignore the slot field; keep it moving anyway
        it.slot  = SLOT_W'($urandom);
        it.red   = r;
        it.green = g;
        it.blue  = b;
        it.alpha = a;
        return it;
    endfunction

    // Move a channel a few steps, clamped to the channel range
    function automatic logic [CHAN_W-1:0] nudge(logic [CHAN_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return CHAN_W'(v);
    endfunction

    function automatic quant_req_t random_pixel();
        logic [COLOR_W-1:0] near;
        logic [CHAN_W-1:0]  a;
        int                 pick;
        int                 roll;
        pick = $urandom_range(99);
        roll = $urandom_range(99);
        a    = (roll < 20) ? '0 : (roll < 30) ? 8'hFF : CHAN_W'($urandom);
        near = palette_model[$urandom_range(DEPTH - 1)];
        // Land near a stored color so that close calls and ties show up
        if (pick < 40)
            return pixel_item(nudge(near[23:16]), nudge(near[15:8]), nudge(near[7:0]), a);
        // Cube corners
        if (pick < 50)
            return pixel_item({CHAN_W{$urandom_range(1) == 1}}, {CHAN_W{$urandom_range(1) == 1}},
                              {CHAN_W{$urandom_range(1) == 1}}, a);
        return pixel_item(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), a);
    endfunction

    function automatic quant_req_t random_load();
        logic [COLOR_W-1:0] twin;
        twin = palette_model[$urandom_range(DEPTH - 1)];
        // Duplicate an existing entry now and then to force equal distances
        if ($urandom_range(99) < 15)
            return load_item($urandom_range(DEPTH - 1), twin[23:16], twin[15:8], twin[7:0]);
        return load_item($urandom_range(DEPTH - 1), CHAN_W'($urandom), CHAN_W'($urandom),
                         CHAN_W'($urandom));
    endfunction

    // ------------------------------------------------------------------------
    // Input channel driver
    // ------------------------------------------------------------------------

    // Offer one transaction and hold it until the block takes it. Payload and
    // valid change only at the falling edge; the handshake is sampled at the
    // rising edge, where in_stall still shows its pre-edge value.
    task automatic offer_transaction(quant_req_t item);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= item.req;
        entry_index <= item.slot;
        in_red      <= item.red;
        in_green    <= item.green;
        in_blue     <= item.blue;
        in_alpha    <= item.alpha;
        do
            @(posedge clk);
        while (in_stall);
        // Accepted at this edge: advance the local state
        if (item.req == REQ_LOAD)
            palette_model[item.slot] = {item.red, item.green, item.blue};
        else
            color_queue.push_back(nearest_color(item));
    endtask

    // Drop valid, wait for every owed result, then let trailing loads settle
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (color_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        case (idx)
            REG_FIXED_MODE:    fixed_mode_q  = value[0];
            REG_FIXED_RED:     fixed_red_q   = value;
            REG_FIXED_GREEN:   fixed_green_q = value;
            REG_FIXED_BLUE:    fixed_blue_q  = value;
            REG_PALETTE_COUNT: count_q       = value[IDX_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Write all five registers; call only when the block is idle
    task automatic apply_setting(logic mode, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                 logic [CHAN_W-1:0] b, logic [IDX_W-1:0] count);
        write_reg(REG_FIXED_MODE, CFG_DATA_W'(mode));
        write_reg(REG_FIXED_RED, r);
        write_reg(REG_FIXED_GREEN, g);
        write_reg(REG_FIXED_BLUE, b);
        write_reg(REG_PALETTE_COUNT, CFG_DATA_W'(count));
    endtask

    // ------------------------------------------------------------------------
    // Output channel: sink and checker
    // ------------------------------------------------------------------------

    // Stall at random, or hold off entirely while hold_left runs down
    initial
    begin : result_sink
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= idle_on && ($urandom_range(99) < 25);
        end
    end

    task automatic log_failure(string msg);
        err_count++;
        if (err_count <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Compare every accepted result with the oldest owed color
    always @(posedge clk)
    begin : result_check
        quant_color_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (color_queue.size() == 0)
                log_failure($sformatf("result with none owed: rgb %02h%02h%02h slot %0d",
                                      out_red, out_green, out_blue, chosen_index));
            else
            begin
                want = color_queue.pop_front();
                if (out_red !== want.red || out_green !== want.green ||
                    out_blue !== want.blue || chosen_index !== want.slot_idx)
                    log_failure($sformatf("rgb %02h%02h%02h slot %0d, want %02h%02h%02h slot %0d",
                                          out_red, out_green, out_blue, chosen_index,
                                          want.red, want.green, want.blue, want.slot_idx));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty palette after reset: every nearest search ends on white at slot 0,
    // and fixed mode with the reset colors paints opaque pixels black.
    task automatic test_after_reset();
        offer_transaction(pixel_item(8'h00, 8'h00, 8'h00, 8'h00));
        offer_transaction(pixel_item(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        settle();
        write_reg(REG_FIXED_MODE, 8'h01);
        offer_transaction(pixel_item(8'h12, 8'h34, 8'h56, 8'h01));
        offer_transaction(pixel_item(8'h12, 8'h34, 8'h56, 8'h00));
        settle();
        write_reg(REG_FIXED_MODE, 8'h00);
    endtask

    // Small hand-built palette: exact hits, ties between equal entries, a
    // loaded white against the implicit one, and counts that cut the scan short.
    task automatic test_nearest_directed();
        offer_transaction(load_item(0, 8'h00, 8'h00, 8'h00));
        offer_transaction(load_item(1, 8'hFF, 8'h00, 8'h00));
        offer_transaction(load_item(2, 8'h00, 8'h00, 8'h00));
        offer_transaction(load_item(3, 8'hFF, 8'hFF, 8'hFF));
        offer_transaction(load_item(63, 8'h55, 8'hAA, 8'h33));
        settle();
        write_reg(REG_PALETTE_COUNT, 8'd4);
        offer_transaction(pixel_item(8'h01, 8'h01, 8'h01, 8'h80));
        offer_transaction(pixel_item(8'hFA, 8'h0A, 8'h0A, 8'h00));
        offer_transaction(pixel_item(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        offer_transaction(pixel_item(8'h80, 8'h80, 8'h80, 8'h7F));
        settle();
        // Slot 3 drops out: white now comes from the implicit entry
        write_reg(REG_PALETTE_COUNT, 8'd3);
        offer_transaction(pixel_item(8'hFF, 8'hFF, 8'hFF, 8'h00));
        offer_transaction(pixel_item(8'h00, 8'h00, 8'h01, 8'h00));
        settle();
        write_reg(REG_PALETTE_COUNT, 8'd1);
        offer_transaction(pixel_item(8'hC8, 8'hC8, 8'hC8, 8'h01));
        settle();
    endtask

    // Fixed mode: alpha zero versus nonzero, with extreme fixed colors
    task automatic test_fixed_color();
        apply_setting(1'b1, 8'hFF, 8'h00, 8'h80, 7'd4);
        offer_transaction(pixel_item(8'h00, 8'h00, 8'h00, 8'hFF));
        offer_transaction(pixel_item(8'h00, 8'h00, 8'h00, 8'h00));
        offer_transaction(pixel_item(8'hFF, 8'hFF, 8'hFF, 8'h01));
        settle();
        apply_setting(1'b1, 8'h00, 8'hFF, 8'h00, 7'd0);
        offer_transaction(pixel_item(8'h33, 8'h66, 8'h99, 8'h80));
        settle();
    endtask

    // Fill the whole store, then run phases of mixed traffic under a spread of
    // settings. Phases 0 through 4 pin the extremes; the rest draw at random.
    task automatic test_random_traffic();
        logic [IDX_W-1:0] count;
        int               roll;
        for (int s = 0; s < DEPTH; s++)
            offer_transaction(load_item(s, CHAN_W'($urandom), CHAN_W'($urandom),
                                        CHAN_W'($urandom)));
        settle();
        for (int p = 0; p < PHASES; p++)
        begin
            roll = $urandom_range(99);
            // Favor short scans; full and saturated counts show up less often
            count = (roll < 15) ? IDX_W'(0) :
                    (roll < 25) ? IDX_W'(DEPTH) :
                    (roll < 30) ? IDX_W'($urandom_range(127, DEPTH + 1)) :
                                  IDX_W'($urandom_range(16, 1));
            case (p)
                0: apply_setting(1'b0, 8'h00, 8'h00, 8'h00, IDX_W'(DEPTH));
                1: apply_setting(1'b0, 8'h80, 8'h01, 8'hFE, 7'd127);
                2: apply_setting(1'b0, 8'hFF, 8'hFF, 8'hFF, 7'd0);
                3: apply_setting(1'b1, 8'h00, 8'h00, 8'h00, IDX_W'(DEPTH + 1));
                4: apply_setting(1'b1, 8'hFF, 8'hFF, 8'hFF, 7'd1);
                default: apply_setting($urandom_range(99) < 20, CHAN_W'($urandom),
                                       CHAN_W'($urandom), CHAN_W'($urandom), count);
            endcase
            // One phase runs flat out on both channels
            idle_on = (p != 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 30)
                    offer_transaction(random_load());
                else
                    offer_transaction(random_pixel());
            end
            settle();
            idle_on = 1'b1;
        end
    endtask

    // Hold the output off for a long stretch while pixels keep coming, so the
    // result register fills and the input channel backs up.
    task automatic test_output_backpressure();
        apply_setting(1'b0, 8'h00, 8'h00, 8'h00, 7'd8);
        hold_left = 300;
        for (int n = 0; n < 20; n++)
        begin
            if (n % 5 == 4)
                offer_transaction(random_load());
            else
                offer_transaction(random_pixel());
        end
        settle();
    endtask

    initial
    begin : main
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = REQ_LOAD;
        entry_index  = '0;
        in_red       = '0;
        in_green     = '0;
        in_blue      = '0;
        in_alpha     = '0;
        cfg_write_en = 1'b0;
        cfg_index    = REG_FIXED_MODE;
        cfg_data     = '0;
        fixed_mode_q  = 1'b0;
        fixed_red_q   = '0;
        fixed_green_q = '0;
        fixed_blue_q  = '0;
        count_q       = '0;
        foreach (palette_model[i])
            palette_model[i] = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_nearest_directed();
        test_fixed_color();
        test_random_traffic();
        test_output_backpressure();

        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
